// ===== sv/stis_pkg.sv =====
// Shared types and constants for the sorted table insertion search block.
// Holds the operation codes, field widths and controller/datapath interface structs.
// No dependencies.
package stis_pkg;

  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 11;

  // Operation codes carried by the func field of a transaction.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Word index of the mode register on the configuration port.
  localparam logic REG_LEFTMOST = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic append;
    logic query_init;
    logic probe;
    logic update;
    logic emit_lo;
    logic emit_mid;
  } stis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_open;
    logic found;
  } stis_stat_t;

endpackage

// ===== sv/stis_ram.sv =====
// Generic single-port RAM with a registered read port.
// Width and depth are parameters; no package dependencies.
module stis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/stis_ctrl.sv =====
// Controller state machine for the sorted table insertion search block.
// Depends on stis_pkg for operation codes and the command and status structs.
module stis_ctrl
  import stis_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FUNC_W-1:0] func_i,
  input  stis_stat_t        stat_i,
  output stis_cmd_t         cmd_o,
  output logic              busy_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (func_i)
            FUNC_CLEAR:  cmd_o.clear = 1'b1;
            FUNC_APPEND: cmd_o.append = 1'b1;
            FUNC_QUERY: begin
              cmd_o.query_init = 1'b1;
              state_d          = S_PROBE;
            end
            default: ;
          endcase
        end
      end
      S_PROBE: begin
        if (stat_i.range_open) begin
          cmd_o.probe = 1'b1;
          state_d     = S_CMP;
        end else begin
          cmd_o.emit_lo = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_CMP: begin
        if (stat_i.found) begin
          cmd_o.emit_mid = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = S_PROBE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef SYNTH
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command in a cycle");

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_lo || cmd_o.emit_mid) |=> (state_q == S_IDLE))
    else $error("controller did not return to idle after a result");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i && func_i == FUNC_QUERY) |=> busy_o)
    else $error("accepted query did not raise busy");
`endif

endmodule

// ===== sv/stis_dp.sv =====
// Datapath for the sorted table insertion search block: table memory, entry
// count, search bounds and the result register. Depends on stis_pkg and stis_ram.
module stis_dp
  import stis_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  stis_cmd_t                 cmd_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      leftmost_i,
  output stis_stat_t                stat_o,
  output logic                      done_o,
  output logic [INDEX_W-1:0]        insert_index_o
);

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   lo_q, hip1_q, mid_q;
  logic [VALUE_W-1:0] target_q;
  logic               done_q;
  logic [INDEX_W-1:0] index_q;

  logic [CNT_W-1:0]   span;
  logic [CNT_W-1:0]   mid_next;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [VALUE_W-1:0] ram_rdata;
  logic               lt, eq;

  // The upper bound is kept as hi + 1 so that every bound stays unsigned.
  assign span     = CNT_W'(hip1_q - lo_q - CNT_W'(1));
  assign mid_next = CNT_W'(lo_q + (span >> 1));

  assign ram_we   = cmd_i.append && (count_q < CNT_W'(TABLE_DEPTH));
  assign ram_addr = cmd_i.append ? count_q[ADDR_W-1:0] : mid_next[ADDR_W-1:0];

  stis_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (value_i),
    .rdata_o (ram_rdata)
  );

  assign lt = ($signed(ram_rdata) < $signed(target_q));
  assign eq = (ram_rdata == target_q);

  assign stat_o.range_open = (lo_q < hip1_q);
  assign stat_o.found      = eq && !leftmost_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (ram_we) begin
        count_q <= CNT_W'(count_q + CNT_W'(1));
      end
      done_q <= cmd_i.emit_lo || cmd_i.emit_mid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_init) begin
      lo_q     <= '0;
      hip1_q   <= count_q;
      target_q <= value_i;
    end else if (cmd_i.update) begin
      if (lt) begin
        lo_q <= CNT_W'(mid_q + CNT_W'(1));
      end else begin
        hip1_q <= mid_q;
      end
    end
    if (cmd_i.probe) begin
      mid_q <= mid_next;
    end
    if (cmd_i.emit_lo) begin
      index_q <= INDEX_W'(lo_q);
    end else if (cmd_i.emit_mid) begin
      index_q <= INDEX_W'(mid_q);
    end
  end

  assign done_o         = done_q;
  assign insert_index_o = index_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_mid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> (mid_q >= lo_q) && (mid_q < hip1_q))
    else $error("probe index outside the search interval");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

// ===== sv/sorted_table_insertion_search.sv =====
// Top level of the sorted table insertion search block.
// Depends on stis_pkg, stis_ctrl, stis_dp and stis_ram.
//
// Usage: software loads signed 32-bit values in ascending order and then asks
// for the insertion index of a target. A transaction is accepted at a rising
// edge where start is high and busy is low; func_i selects clear, append or
// query and value_i carries the value or the search target. Clear and append
// complete in the accepting cycle and keep busy low, so they may be issued
// back to back; an append to a full table is dropped, and an unused func
// code is ignored. A query raises busy and runs a binary search, each probe
// being one read of the single-port table RAM followed by one signed compare.
// A search ends on an empty range or, in midpoint mode, on an equal entry;
// done_o rises on the same edge on which busy falls. For a full table of
// 1024 entries at most 11 probes are made. No new transaction is accepted
// until busy has fallen, so queries do not overlap.
// done_o is high for exactly one cycle with insert_index_o valid; the
// receiver cannot stall, so a result must be taken when it is shown.
// The mode register (word 0 of the APB port) picks the leftmost insertion
// position (1, its reset value) or the first equal midpoint (0).
// Reset clears the entry count, the controller and the strobe; table words
// are not cleared since only entries below the count are ever read.
module sorted_table_insertion_search
  import stis_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Command channel.
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic signed [VALUE_W-1:0] value_i,
  // Result channel.
  output logic                      done_o,
  output logic [INDEX_W-1:0]        insert_index_o,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  stis_cmd_t  cmd;
  stis_stat_t stat;
  logic       leftmost_q;
  logic       cfg_write;

  // The port has no wait states, so the access phase always completes.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Mode register; writes to any other word are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leftmost_q <= 1'b1;
    end else if (cfg_write && (paddr[2] == REG_LEFTMOST)) begin
      leftmost_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_LEFTMOST) ? {31'b0, leftmost_q} : 32'b0;

  stis_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  stis_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .value_i        (value_i),
    .leftmost_i     (leftmost_q),
    .stat_o         (stat),
    .done_o         (done_o),
    .insert_index_o (insert_index_o)
  );

endmodule
